// ===== hdl/tsl_pkg.sv =====
`timescale 1ns / 1ps

package tsl_pkg;

  // Scanner states.
  typedef enum logic [4:0] {
    ST_GAP,
    ST_COMMENT,
    ST_WORD,
    ST_MINUS,
    ST_RLEAD,
    ST_STR,
    ST_STR_ESC,
    ST_ZERO,
    ST_INT,
    ST_FRAC,
    ST_EXP,
    ST_RGX,
    ST_RGX_ESC,
    ST_FLAGS,
    ST_HALT,
    ST_IDENT
  } tsl_state_t;

  // Number base of the open integer.
  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT,
    BASE_BIN
  } tsl_base_t;

  // Result kinds.
  typedef enum logic [1:0] {
    RK_TOKEN,
    RK_ERROR,
    RK_END
  } tsl_rkind_t;

  // Token kinds.
  localparam logic [2:0] TK_WORD   = 3'd0;
  localparam logic [2:0] TK_STRING = 3'd1;
  localparam logic [2:0] TK_REGEX  = 3'd2;
  localparam logic [2:0] TK_INT    = 3'd3;
  localparam logic [2:0] TK_REAL   = 3'd4;
  localparam logic [2:0] TK_IDENT  = 3'd5;

  // Error codes.
  localparam logic [2:0] EC_NONE      = 3'd0;
  localparam logic [2:0] EC_NO_SEP    = 3'd1;
  localparam logic [2:0] EC_STR_END   = 3'd2;
  localparam logic [2:0] EC_MULTILINE = 3'd3;
  localparam logic [2:0] EC_BAD_DIGIT = 3'd4;
  localparam logic [2:0] EC_RGX_END   = 3'd5;
  localparam logic [2:0] EC_BAD_FLAG  = 3'd6;

  // Character codes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_LC  = 8'h66;
  localparam logic [7:0] CH_LG     = 8'h67;
  localparam logic [7:0] CH_LI     = 8'h69;
  localparam logic [7:0] CH_LM     = 8'h6D;
  localparam logic [7:0] CH_LO     = 8'h6F;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_LX     = 8'h78;

  // Control state of the scanner.
  typedef struct packed {
    tsl_state_t state;
    logic       first;
    logic       sep;
    tsl_base_t  base;
    logic       real_seen;
    logic       err;
  } tsl_ctl_t;

  // Control part of one result.
  typedef struct packed {
    logic       valid;
    tsl_rkind_t kind;
    logic [2:0] tkind;
    logic [2:0] ecode;
    logic       done;
  } tsl_res_t;

  localparam tsl_ctl_t CTL_RESET = '{
    state: ST_GAP, first: 1'b1, sep: 1'b0, base: BASE_DEC, real_seen: 1'b0, err: 1'b0
  };

endpackage

// ===== hdl/tsl_step.sv =====
`timescale 1ns / 1ps

module tsl_step import tsl_pkg::*; #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  tsl_ctl_t               ctl_i,
  input  logic [LINE_BITS-1:0]   line_i,
  input  logic [COLUMN_BITS-1:0] col_i,
  input  logic [LINE_BITS-1:0]   tok_line_i,
  input  logic [COLUMN_BITS-1:0] tok_col_i,
  input  logic [LENGTH_BITS-1:0] tok_len_i,
  input  logic [7:0]             ch_i,
  input  logic                   last_i,
  output tsl_ctl_t               ctl_nxt,
  output logic [LINE_BITS-1:0]   line_nxt,
  output logic [COLUMN_BITS-1:0] col_nxt,
  output logic [LINE_BITS-1:0]   tok_line_nxt,
  output logic [COLUMN_BITS-1:0] tok_col_nxt,
  output logic [LENGTH_BITS-1:0] tok_len_nxt,
  output tsl_res_t               res_o,
  output logic [LINE_BITS-1:0]   res_line_o,
  output logic [COLUMN_BITS-1:0] res_col_o,
  output logic [LENGTH_BITS-1:0] res_len_o
);

  logic                   is_sp;
  logic                   is_dec;
  logic                   is_hex;
  logic                   is_oct;
  logic                   is_bin;
  logic                   is_flag;
  logic                   digit_ok;
  logic [2:0]             num_kind;
  logic [LENGTH_BITS-1:0] len_inc;

  // Character classes.
  assign is_sp   = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_LF) ||
                   (ch_i == CH_CR);
  assign is_dec  = (ch_i >= CH_0) && (ch_i <= CH_9);
  assign is_hex  = is_dec || ((ch_i >= CH_LA) && (ch_i <= CH_LF_LC)) ||
                   ((ch_i >= CH_UA) && (ch_i <= CH_UF));
  assign is_oct  = (ch_i >= CH_0) && (ch_i <= CH_7);
  assign is_bin  = (ch_i == CH_0) || (ch_i == CH_1);
  assign is_flag = (ch_i == CH_LG) || (ch_i == CH_LX) || (ch_i == CH_LI) ||
                   (ch_i == CH_LA) || (ch_i == CH_LM) || (ch_i == CH_LS);
  assign digit_ok = ((ctl_i.base == BASE_HEX) && is_hex) ||
                    ((ctl_i.base == BASE_OCT) && is_oct) ||
                    ((ctl_i.base == BASE_BIN) && is_bin);
  assign num_kind = ctl_i.real_seen ? TK_REAL : TK_INT;
  assign len_inc  = (&tok_len_i) ? tok_len_i : tok_len_i + LENGTH_BITS'(1);

  // One byte of scanning, then the end-of-input handling.
  always_comb begin
    ctl_nxt      = ctl_i;
    tok_line_nxt = tok_line_i;
    tok_col_nxt  = tok_col_i;
    tok_len_nxt  = tok_len_i;
    res_o        = '{valid: 1'b0, kind: RK_TOKEN, tkind: TK_WORD, ecode: EC_NONE,
                     done: 1'b0};

    // Position counters run on every byte, held error or not.
    if (ch_i == CH_LF) begin
      line_nxt = (&line_i) ? line_i : line_i + LINE_BITS'(1);
      col_nxt  = '0;
    end else begin
      line_nxt = line_i;
      col_nxt  = (&col_i) ? col_i : col_i + COLUMN_BITS'(1);
    end

    if (!ctl_i.err) begin
      unique case (ctl_i.state)
        ST_GAP: begin
          if (is_sp) begin
            ctl_nxt.sep = 1'b1;
          end else if (ch_i == CH_HASH) begin
            ctl_nxt.sep   = 1'b1;
            ctl_nxt.state = ST_COMMENT;
          end else begin
            tok_line_nxt = line_i;
            tok_col_nxt  = col_i;
            if (!ctl_i.sep && !ctl_i.first) begin
              tok_len_nxt   = '0;
              res_o.valid   = 1'b1;
              res_o.kind    = RK_ERROR;
              res_o.tkind   = TK_WORD;
              res_o.ecode   = EC_NO_SEP;
              ctl_nxt.err   = 1'b1;
              ctl_nxt.state = ST_HALT;
            end else begin
              ctl_nxt.first     = 1'b0;
              ctl_nxt.sep       = 1'b0;
              ctl_nxt.base      = BASE_DEC;
              ctl_nxt.real_seen = 1'b0;
              tok_len_nxt       = LENGTH_BITS'(1);
              priority if (ch_i == CH_QUOTE) ctl_nxt.state = ST_STR;
              else if (ch_i == CH_0)         ctl_nxt.state = ST_ZERO;
              else if (is_dec)               ctl_nxt.state = ST_INT;
              else if (ch_i == CH_COLON)     ctl_nxt.state = ST_IDENT;
              else if (ch_i == CH_MINUS)     ctl_nxt.state = ST_MINUS;
              else if (ch_i == CH_LR)        ctl_nxt.state = ST_RLEAD;
              else                           ctl_nxt.state = ST_WORD;
            end
          end
        end
        ST_COMMENT: begin
          if (ch_i == CH_LF) ctl_nxt.state = ST_GAP;
        end
        ST_WORD, ST_IDENT: begin
          if (is_sp) begin
            res_o.valid   = 1'b1;
            res_o.tkind   = (ctl_i.state == ST_IDENT) ? TK_IDENT : TK_WORD;
            ctl_nxt.state = ST_GAP;
            ctl_nxt.sep   = 1'b1;
          end else begin
            tok_len_nxt = len_inc;
          end
        end
        ST_MINUS, ST_RLEAD: begin
          // A lone minus or r falls back to a word unless a number or regex follows.
          if (is_sp) begin
            res_o.valid   = 1'b1;
            res_o.tkind   = TK_WORD;
            ctl_nxt.state = ST_GAP;
            ctl_nxt.sep   = 1'b1;
          end else begin
            tok_len_nxt = len_inc;
            priority if ((ctl_i.state == ST_MINUS) && (ch_i == CH_0)) ctl_nxt.state = ST_ZERO;
            else if ((ctl_i.state == ST_MINUS) && is_dec)            ctl_nxt.state = ST_INT;
            else if ((ctl_i.state == ST_RLEAD) && (ch_i == CH_SLASH)) ctl_nxt.state = ST_RGX;
            else                                                      ctl_nxt.state = ST_WORD;
          end
        end
        ST_STR: begin
          priority if (ch_i == CH_BSLASH) begin
            tok_len_nxt   = len_inc;
            ctl_nxt.state = ST_STR_ESC;
          end else if (ch_i == CH_LF) begin
            res_o.valid   = 1'b1;
            res_o.kind    = RK_ERROR;
            res_o.tkind   = TK_STRING;
            res_o.ecode   = EC_MULTILINE;
            ctl_nxt.err   = 1'b1;
            ctl_nxt.state = ST_HALT;
          end else if (ch_i == CH_QUOTE) begin
            // The closing quote ends the string; the next token still needs a gap.
            tok_len_nxt   = len_inc;
            res_o.valid   = 1'b1;
            res_o.tkind   = TK_STRING;
            ctl_nxt.state = ST_GAP;
            ctl_nxt.sep   = 1'b0;
          end else begin
            tok_len_nxt = len_inc;
          end
        end
        ST_STR_ESC: begin
          tok_len_nxt   = len_inc;
          ctl_nxt.state = ST_STR;
        end
        ST_ZERO, ST_INT, ST_FRAC, ST_EXP: begin
          ctl_nxt.state = (ctl_i.state == ST_ZERO) ? ST_INT : ctl_i.state;
          priority if ((ctl_i.state == ST_ZERO) && (ch_i == CH_LX)) begin
            tok_len_nxt  = len_inc;
            ctl_nxt.base = BASE_HEX;
          end else if ((ctl_i.state == ST_ZERO) && (ch_i == CH_LO)) begin
            tok_len_nxt  = len_inc;
            ctl_nxt.base = BASE_OCT;
          end else if ((ctl_i.state == ST_ZERO) && (ch_i == CH_LB)) begin
            tok_len_nxt  = len_inc;
            ctl_nxt.base = BASE_BIN;
          end else if (is_sp) begin
            res_o.valid   = 1'b1;
            res_o.tkind   = num_kind;
            ctl_nxt.state = ST_GAP;
            ctl_nxt.sep   = 1'b1;
          end else if ((ctl_i.base == BASE_DEC) && is_dec) begin
            tok_len_nxt = len_inc;
          end else if ((ctl_i.base == BASE_DEC) && (ch_i == CH_DOT) &&
                       (ctl_nxt.state == ST_INT)) begin
            tok_len_nxt       = len_inc;
            ctl_nxt.real_seen = 1'b1;
            ctl_nxt.state     = ST_FRAC;
          end else if ((ctl_i.base == BASE_DEC) && (ch_i == CH_LE) &&
                       (ctl_nxt.state != ST_EXP)) begin
            tok_len_nxt       = len_inc;
            ctl_nxt.real_seen = 1'b1;
            ctl_nxt.state     = ST_EXP;
          end else if ((ctl_i.base != BASE_DEC) && digit_ok) begin
            tok_len_nxt = len_inc;
          end else begin
            res_o.valid   = 1'b1;
            res_o.kind    = RK_ERROR;
            res_o.tkind   = num_kind;
            res_o.ecode   = EC_BAD_DIGIT;
            ctl_nxt.err   = 1'b1;
            ctl_nxt.state = ST_HALT;
          end
        end
        ST_RGX: begin
          tok_len_nxt = len_inc;
          if (ch_i == CH_BSLASH) ctl_nxt.state = ST_RGX_ESC;
          else if (ch_i == CH_SLASH) ctl_nxt.state = ST_FLAGS;
        end
        ST_RGX_ESC: begin
          tok_len_nxt   = len_inc;
          ctl_nxt.state = ST_RGX;
        end
        ST_FLAGS: begin
          priority if (is_flag) begin
            tok_len_nxt = len_inc;
          end else if (is_sp) begin
            res_o.valid   = 1'b1;
            res_o.tkind   = TK_REGEX;
            ctl_nxt.state = ST_GAP;
            ctl_nxt.sep   = 1'b1;
          end else begin
            res_o.valid   = 1'b1;
            res_o.kind    = RK_ERROR;
            res_o.tkind   = TK_REGEX;
            res_o.ecode   = EC_BAD_FLAG;
            ctl_nxt.err   = 1'b1;
            ctl_nxt.state = ST_HALT;
          end
        end
        default: begin
          // Halted: bytes are only counted.
        end
      endcase
    end

    // End of input: close what is open (an open string or regex is an error), or report the plain end.
    if (last_i) begin
      if (!res_o.valid) begin
        res_o.valid = 1'b1;
        unique case (ctl_nxt.state)
          ST_WORD, ST_MINUS, ST_RLEAD: res_o.tkind = TK_WORD;
          ST_IDENT:                    res_o.tkind = TK_IDENT;
          ST_ZERO, ST_INT, ST_FRAC, ST_EXP: begin
            res_o.tkind = ctl_nxt.real_seen ? TK_REAL : TK_INT;
          end
          ST_FLAGS:                    res_o.tkind = TK_REGEX;
          ST_STR, ST_STR_ESC: begin
            res_o.kind  = RK_ERROR;
            res_o.tkind = TK_STRING;
            res_o.ecode = EC_STR_END;
            ctl_nxt.err = 1'b1;
          end
          ST_RGX, ST_RGX_ESC: begin
            res_o.kind  = RK_ERROR;
            res_o.tkind = TK_REGEX;
            res_o.ecode = EC_RGX_END;
            ctl_nxt.err = 1'b1;
          end
          default:                     res_o.kind = RK_END;
        endcase
      end
      // An error held from an earlier byte turns into a plain end.
      if (ctl_nxt.err && (res_o.kind != RK_ERROR)) begin
        res_o.kind  = RK_END;
        res_o.tkind = TK_WORD;
        res_o.ecode = EC_NONE;
      end
      res_o.done = 1'b1;
    end

    // Result position: the token start, or just past the text for an end.
    if (res_o.kind == RK_END) begin
      res_line_o = line_nxt;
      res_col_o  = col_nxt;
      res_len_o  = '0;
    end else begin
      res_line_o = tok_line_nxt;
      res_col_o  = tok_col_nxt;
      res_len_o  = tok_len_nxt;
    end

    // After the last byte everything starts over.
    if (last_i) begin
      ctl_nxt      = CTL_RESET;
      line_nxt     = LINE_BITS'(1);
      col_nxt      = '0;
      tok_line_nxt = '0;
      tok_col_nxt  = '0;
      tok_len_nxt  = '0;
    end
  end

endmodule

// ===== hdl/token_stream_lexer.sv =====
`timescale 1ns / 1ps

// Channel  Direction  tdata                                         tuser        tlast
// in_      input      char_in[7:0]                                  -            last_byte
// out_     output     token_kind, error_code, start_line,           result_kind  input_done
//                     start_column, token_length (low bit up)
//
// One byte per cycle unless the scan stage stalls: a byte sits in the input register,
// is scanned by the step logic, and its result (if any) lands in the output register.
// Reset (rst_n, synchronous) puts the scanner between tokens at line 1, column 0. A result
// waiting in the output register stalls the scan stage; the input register keeps taking
// a byte whenever the scan stage moves.
module token_stream_lexer import tsl_pkg::*; #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // char_in[7:0]
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  // token_kind[2:0], error_code[5:3], start_line, start_column, token_length, zero pad
  output logic [((6 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [1:0]          out_tuser,  // result_kind[1:0]
  output logic                out_tlast
);

  localparam int DataW = ((6 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 7) / 8) * 8;

  logic                   in_v_r;
  logic [7:0]             in_ch_r;
  logic                   in_last_r;
  logic                   adv;

  tsl_ctl_t               ctl_r,      ctl_nxt;
  logic [LINE_BITS-1:0]   line_r,     line_nxt;
  logic [COLUMN_BITS-1:0] col_r,      col_nxt;
  logic [LINE_BITS-1:0]   tok_line_r, tok_line_nxt;
  logic [COLUMN_BITS-1:0] tok_col_r,  tok_col_nxt;
  logic [LENGTH_BITS-1:0] tok_len_r,  tok_len_nxt;

  tsl_res_t               res;
  logic [LINE_BITS-1:0]   res_line;
  logic [COLUMN_BITS-1:0] res_col;
  logic [LENGTH_BITS-1:0] res_len;

  logic                   out_v_r;
  tsl_res_t               out_res_r;
  logic [LINE_BITS-1:0]   out_line_r;
  logic [COLUMN_BITS-1:0] out_col_r;
  logic [LENGTH_BITS-1:0] out_len_r;

  // The scan stage moves when a byte is held and the output register is free or being emptied.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_ch_r   <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  tsl_step #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .ctl_i        (ctl_r),
    .line_i       (line_r),
    .col_i        (col_r),
    .tok_line_i   (tok_line_r),
    .tok_col_i    (tok_col_r),
    .tok_len_i    (tok_len_r),
    .ch_i         (in_ch_r),
    .last_i       (in_last_r),
    .ctl_nxt      (ctl_nxt),
    .line_nxt     (line_nxt),
    .col_nxt      (col_nxt),
    .tok_line_nxt (tok_line_nxt),
    .tok_col_nxt  (tok_col_nxt),
    .tok_len_nxt  (tok_len_nxt),
    .res_o        (res),
    .res_line_o   (res_line),
    .res_col_o    (res_col),
    .res_len_o    (res_len)
  );

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r      <= CTL_RESET;
      line_r     <= LINE_BITS'(1);
      col_r      <= '0;
      tok_line_r <= '0;
      tok_col_r  <= '0;
      tok_len_r  <= '0;
    end else if (adv) begin
      ctl_r      <= ctl_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_len_r  <= tok_len_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res.valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (adv && res.valid) begin
      out_res_r  <= res;
      out_line_r <= res_line;
      out_col_r  <= res_col;
      out_len_r  <= res_len;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.done;
  assign out_tdata  = DataW'({out_len_r, out_col_r, out_line_r, out_res_r.ecode,
                              out_res_r.tkind});

endmodule
